// ===== design/irfce_pkg.sv =====
// Shared constants, command codes and helpers for the region flip/copy engine.
`timescale 1ns / 1ps
`default_nettype none
package irfce_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  localparam int CoordW = 9;
  localparam int ColorW = 24;
  localparam int StatW  = 3;
  localparam int KindW  = 3;

  // command kinds
  localparam logic [KindW-1:0] KIND_WRITE   = 3'd0;
  localparam logic [KindW-1:0] KIND_READ    = 3'd1;
  localparam logic [KindW-1:0] KIND_FLIPROW = 3'd2;
  localparam logic [KindW-1:0] KIND_FLIPCOL = 3'd3;
  localparam logic [KindW-1:0] KIND_COPY    = 3'd4;
  localparam logic [KindW-1:0] KIND_REPLACE = 3'd5;
  localparam logic [KindW-1:0] KIND_SETCHAN = 3'd6;
  localparam logic [KindW-1:0] KIND_NOP     = 3'd7;

  // status codes
  localparam logic [StatW-1:0] ST_OK        = 3'd0;
  localparam logic [StatW-1:0] ST_FIRST_OUT = 3'd1;
  localparam logic [StatW-1:0] ST_SECOND_OUT= 3'd2;
  localparam logic [StatW-1:0] ST_X_ORDER   = 3'd3;
  localparam logic [StatW-1:0] ST_Y_ORDER   = 3'd4;
  localparam logic [StatW-1:0] ST_DEST_OUT  = 3'd5;
  localparam logic [StatW-1:0] ST_DEST_SMALL= 3'd6;
  localparam logic [StatW-1:0] ST_ABSENT    = 3'd7;

  // channel selects
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;
  localparam logic [1:0] CH_NONE  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  localparam int InDataW  = 112;
  localparam int OutDataW = 32;

  function automatic logic [CoordW-1:0] clamp_dim(input logic [CoordW-1:0] v, input int maxv);
    logic [CoordW-1:0] d;
    d = v;
    if (d == '0) d = CoordW'(1);
    if (int'(d) > maxv) d = CoordW'(maxv);
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== design/irfce_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module irfce_ram #(
  parameter int Width = 24,
  parameter int Depth = 65536,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic [Width-1:0]   rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== design/image_region_flip_copy_engine.sv =====
// Top level of the region flip/copy engine: command sequencer around frame and scratch RAMs.
// Usage:
//  - Commands arrive on the s_axis channel: tuser is the command kind, tdata the
//    coordinates, colors and channel fields. One request is taken at a time.
//  - Results leave on m_axis: tdata = {read_color, status}, one per command.
//  - Configuration (width, height) is written on the cfg channel while idle;
//    cfg_ready_o is always high. Written values of 0 read as 1 and are capped
//    at MAX_WIDTH / MAX_HEIGHT.
//  - Flow: latch, check, then the walk, then present the result. Flip: two
//    reads and two writes on the frame RAM per swapped pixel pair. Copy:
//    a snapshot pass into the scratch RAM, then a restore pass. Replace color
//    / set channel: a read, then a modify-write, for each pixel of the frame.
//  - Reset clears the sequencer and output register and sets width and height
//    to their defaults; RAM contents are undefined until written.
//  - A result waits in the output register while m_axis_tready is low; the
//    next request is still accepted and worked on, and only its handover
//    waits for the output register to drain.
`timescale 1ns / 1ps
`default_nettype none
module image_region_flip_copy_engine #(
  parameter int MAX_WIDTH  = irfce_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = irfce_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  // command input
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // tdata lsb up: x_first 9, y_first 9, x_second 9, y_second 9, x_dest 9, y_dest 9,
  //   match_color 24, new_color 24, channel_select 2, channel_value 8
  input  wire logic [irfce_pkg::InDataW-1:0] s_axis_tdata,
  // tuser: kind 3
  input  wire logic [irfce_pkg::KindW-1:0]   s_axis_tuser,
  // result output
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // tdata lsb up: status 3, read_color 24, zero pad 5
  output logic [irfce_pkg::OutDataW-1:0]     m_axis_tdata,
  // configuration
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [irfce_pkg::CoordW-1:0] cfg_data_i
);
  localparam int CW    = irfce_pkg::CoordW;
  localparam int PW    = irfce_pkg::ColorW;
  localparam int SW    = irfce_pkg::StatW;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_PRD  = 4'd2;
  localparam logic [3:0] S_SRA  = 4'd3;
  localparam logic [3:0] S_SRB  = 4'd4;
  localparam logic [3:0] S_SWA  = 4'd5;
  localparam logic [3:0] S_SWB  = 4'd6;
  localparam logic [3:0] S_C1R  = 4'd7;
  localparam logic [3:0] S_C1W  = 4'd8;
  localparam logic [3:0] S_C2R  = 4'd9;
  localparam logic [3:0] S_C2W  = 4'd10;
  localparam logic [3:0] S_RMR  = 4'd11;
  localparam logic [3:0] S_RMW  = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] x, input logic [CW-1:0] y);
    return AW'(32'(y) * 32'(MAX_WIDTH) + 32'(x));
  endfunction

  logic [3:0] state_q, state_d;
  logic [CW-1:0] width_q, height_q;

  // latched command
  logic [2:0]    kind_q;
  logic [CW-1:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;
  logic [PW-1:0] match_q, newc_q;
  logic [1:0]    sel_q;
  logic [7:0]    cval_q;

  // walk counters
  logic [CW-1:0] x_q, x_d, y_q, y_d, xlo_q, xlo_d, xhi_q, xhi_d, yhi_q, yhi_d;
  logic          found_q, found_d;
  logic [PW-1:0] tmp_q, tmp_d;
  logic [SW-1:0] res_st_q, res_st_d;
  logic [PW-1:0] res_col_q, res_col_d;

  logic          out_valid_q;
  logic [SW-1:0] out_st_q;
  logic [PW-1:0] out_col_q;

  // RAM ports
  logic          f_we, s_we;
  logic [AW-1:0] f_waddr, f_raddr, s_waddr, s_raddr;
  logic [PW-1:0] f_wdata, f_rdata, s_rdata;

  irfce_ram #(.Width(PW), .Depth(DEPTH)) u_frame (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(f_raddr), .rdata_o(f_rdata)
  );

  irfce_ram #(.Width(PW), .Depth(DEPTH)) u_scratch (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(f_rdata),
    .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_col_q, out_st_q};

  wire s_fire   = s_axis_tvalid & s_axis_tready;
  wire out_free = ~out_valid_q | m_axis_tready;
  wire last_x   = (x_q == xhi_q);
  wire last_px  = last_x & (y_q == yhi_q);

  // check logic on the latched command
  logic [SW-1:0] chk_st;
  logic [CW:0]   fit_x;
  always_comb begin
    fit_x  = {1'b0, x3_q} + {1'b0, x2_q - x1_q};
    chk_st = irfce_pkg::ST_OK;
    case (kind_q)
      irfce_pkg::KIND_WRITE, irfce_pkg::KIND_READ: begin
        if (x1_q >= width_q || y1_q >= height_q) chk_st = irfce_pkg::ST_FIRST_OUT;
      end
      irfce_pkg::KIND_FLIPROW, irfce_pkg::KIND_FLIPCOL, irfce_pkg::KIND_COPY: begin
        if (x1_q >= width_q || y1_q >= height_q)      chk_st = irfce_pkg::ST_FIRST_OUT;
        else if (x2_q >= width_q || y2_q >= height_q) chk_st = irfce_pkg::ST_SECOND_OUT;
        else if (x2_q < x1_q)                         chk_st = irfce_pkg::ST_X_ORDER;
        else if (y2_q > y1_q)                         chk_st = irfce_pkg::ST_Y_ORDER;
        else if (kind_q == irfce_pkg::KIND_COPY) begin
          if (x3_q >= width_q || y3_q >= height_q) chk_st = irfce_pkg::ST_DEST_OUT;
          else if (fit_x >= {1'b0, width_q} || y3_q < (y1_q - y2_q))
            chk_st = irfce_pkg::ST_DEST_SMALL;
        end
      end
      irfce_pkg::KIND_SETCHAN: begin
        if (sel_q == irfce_pkg::CH_NONE) chk_st = irfce_pkg::ST_ABSENT;
      end
      default: chk_st = irfce_pkg::ST_OK;
    endcase
  end

  // mirror partners and pixel modify
  logic [CW:0]   ysum, xsum;
  logic [CW-1:0] y_mir, x_mir, dx, dy, dst_x, dst_y;
  logic [PW-1:0] mod_px;
  always_comb begin
    ysum  = {1'b0, y1_q} + {1'b0, y2_q};
    xsum  = {1'b0, x1_q} + {1'b0, x2_q};
    y_mir = CW'(ysum - {1'b0, y_q});
    x_mir = CW'(xsum - {1'b0, x_q});
    dx    = x_q - x1_q;
    dy    = y_q - y2_q;
    dst_x = x3_q + dx;
    dst_y = y3_q - (y1_q - y_q);
    mod_px = f_rdata;
    case (sel_q)
      irfce_pkg::CH_RED:   mod_px[23:16] = cval_q;
      irfce_pkg::CH_GREEN: mod_px[15:8]  = cval_q;
      default:             mod_px[7:0]   = cval_q;
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    x_d       = x_q;
    y_d       = y_q;
    xlo_d     = xlo_q;
    xhi_d     = xhi_q;
    yhi_d     = yhi_q;
    found_d   = found_q;
    tmp_d     = tmp_q;
    res_st_d  = res_st_q;
    res_col_d = res_col_q;
    f_we      = 1'b0;
    f_waddr   = pix_addr(x_q, y_q);
    f_wdata   = f_rdata;
    f_raddr   = pix_addr(x_q, y_q);
    s_we      = 1'b0;
    s_waddr   = pix_addr(dx, dy);
    s_raddr   = pix_addr(dx, dy);

    // advance the raster walk by one pixel
    if (last_x) begin
      x_d = xlo_q;
      y_d = y_q + CW'(1);
    end else begin
      x_d = x_q + CW'(1);
    end

    unique case (state_q)
      S_IDLE: begin
        x_d = x_q;
        y_d = y_q;
        if (s_fire) state_d = S_CHK;
      end
      S_CHK: begin
        res_st_d  = chk_st;
        res_col_d = '0;
        found_d   = 1'b0;
        x_d       = x1_q;
        y_d       = y2_q;
        xlo_d     = x1_q;
        xhi_d     = x2_q;
        yhi_d     = y1_q;
        state_d   = S_DONE;
        if (chk_st == irfce_pkg::ST_OK) begin
          case (kind_q)
            irfce_pkg::KIND_WRITE: begin
              f_we    = 1'b1;
              f_waddr = pix_addr(x1_q, y1_q);
              f_wdata = newc_q;
            end
            irfce_pkg::KIND_READ: begin
              f_raddr = pix_addr(x1_q, y1_q);
              state_d = S_PRD;
            end
            irfce_pkg::KIND_FLIPROW: begin
              yhi_d   = ysum[CW:1];
              state_d = S_SRA;
            end
            irfce_pkg::KIND_FLIPCOL: begin
              xhi_d   = xsum[CW:1];
              state_d = S_SRA;
            end
            irfce_pkg::KIND_COPY: state_d = S_C1R;
            irfce_pkg::KIND_REPLACE, irfce_pkg::KIND_SETCHAN: begin
              x_d     = '0;
              y_d     = '0;
              xlo_d   = '0;
              xhi_d   = width_q - CW'(1);
              yhi_d   = height_q - CW'(1);
              state_d = S_RMR;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_PRD: begin
        x_d       = x_q;
        y_d       = y_q;
        res_col_d = f_rdata;
        state_d   = S_DONE;
      end
      // swap: read A, read B, write A <= B, write B <= A
      S_SRA: begin
        x_d     = x_q;
        y_d     = y_q;
        state_d = S_SRB;
      end
      S_SRB: begin
        x_d     = x_q;
        y_d     = y_q;
        f_raddr = (kind_q == irfce_pkg::KIND_FLIPROW) ? pix_addr(x_q, y_mir)
                                                       : pix_addr(x_mir, y_q);
        tmp_d   = f_rdata;
        state_d = S_SWA;
      end
      S_SWA: begin
        x_d     = x_q;
        y_d     = y_q;
        f_we    = 1'b1;
        state_d = S_SWB;
      end
      S_SWB: begin
        f_we    = 1'b1;
        f_waddr = (kind_q == irfce_pkg::KIND_FLIPROW) ? pix_addr(x_q, y_mir)
                                                       : pix_addr(x_mir, y_q);
        f_wdata = tmp_q;
        state_d = last_px ? S_DONE : S_SRA;
      end
      // copy, snapshot pass
      S_C1R: begin
        x_d     = x_q;
        y_d     = y_q;
        state_d = S_C1W;
      end
      S_C1W: begin
        s_we = 1'b1;
        if (last_px) begin
          x_d     = x1_q;
          y_d     = y2_q;
          state_d = S_C2R;
        end else begin
          state_d = S_C1R;
        end
      end
      // copy, restore pass
      S_C2R: begin
        x_d     = x_q;
        y_d     = y_q;
        state_d = S_C2W;
      end
      S_C2W: begin
        f_we    = 1'b1;
        f_waddr = pix_addr(dst_x, dst_y);
        f_wdata = s_rdata;
        state_d = last_px ? S_DONE : S_C2R;
      end
      // whole-frame read-modify-write
      S_RMR: begin
        x_d     = x_q;
        y_d     = y_q;
        state_d = S_RMW;
      end
      S_RMW: begin
        if (kind_q == irfce_pkg::KIND_REPLACE) begin
          f_wdata = newc_q;
          if (f_rdata == match_q) begin
            f_we    = 1'b1;
            found_d = 1'b1;
          end
        end else begin
          f_we    = 1'b1;
          f_wdata = mod_px;
        end
        if (last_px) begin
          state_d = S_DONE;
          if (kind_q == irfce_pkg::KIND_REPLACE && !found_d) res_st_d = irfce_pkg::ST_ABSENT;
        end else begin
          state_d = S_RMR;
        end
      end
      S_DONE: begin
        x_d = x_q;
        y_d = y_q;
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= irfce_pkg::clamp_dim(CW'(256), MAX_WIDTH);
      height_q    <= irfce_pkg::clamp_dim(CW'(256), MAX_HEIGHT);
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == irfce_pkg::REG_WIDTH)
          width_q <= irfce_pkg::clamp_dim(cfg_data_i, MAX_WIDTH);
        else if (cfg_index_i == irfce_pkg::REG_HEIGHT)
          height_q <= irfce_pkg::clamp_dim(cfg_data_i, MAX_HEIGHT);
      end
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready)            out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q       <= x_d;
    y_q       <= y_d;
    xlo_q     <= xlo_d;
    xhi_q     <= xhi_d;
    yhi_q     <= yhi_d;
    tmp_q     <= tmp_d;
    res_st_q  <= res_st_d;
    res_col_q <= res_col_d;
    if (state_q == S_DONE && out_free) begin
      out_st_q  <= res_st_q;
      out_col_q <= res_col_q;
    end
    if (s_fire) begin
      kind_q  <= s_axis_tuser;
      x1_q    <= s_axis_tdata[8:0];
      y1_q    <= s_axis_tdata[17:9];
      x2_q    <= s_axis_tdata[26:18];
      y2_q    <= s_axis_tdata[35:27];
      x3_q    <= s_axis_tdata[44:36];
      y3_q    <= s_axis_tdata[53:45];
      match_q <= s_axis_tdata[77:54];
      newc_q  <= s_axis_tdata[101:78];
      sel_q   <= s_axis_tdata[103:102];
      cval_q  <= s_axis_tdata[111:104];
    end
  end
endmodule
`default_nettype wire

// ===== design/irfce_checker.sv =====
// Port-level checker for the region flip/copy engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module irfce_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [irfce_pkg::OutDataW-1:0] m_axis_tdata
);
  // one request in flight: the input closes right after a request
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready after accepted request");

  // a new result only appears while the sequencer is busy finishing
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a command in flight");

  // failed checks never return pixel data
  a_fail_no_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2:0] != irfce_pkg::ST_OK) |-> m_axis_tdata[26:3] == '0)
    else $error("nonzero read color with failing status");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");
endmodule

bind image_region_flip_copy_engine irfce_checker u_irfce_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire
